>>> hw/rtl/fdb_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and tables for the fix distance and bearing block.
// Used by every module under hw/rtl; depends on nothing else.
package fdb_pkg;

   // Default parameter values
   localparam int CORDIC_ITERATIONS_DEF = 24;
   localparam int FRAC_BITS_DEF         = 30;

   // Datapath widths
   localparam int MUL_W  = 36;            // signed multiplier operand width
   localparam int PROD_W = 2 * MUL_W;     // product width
   localparam int CW     = 40;            // CORDIC vector and angle width
   localparam int SQ_W   = 64;            // square root radicand width
   localparam int SQ_STEPS = SQ_W / 2;    // one result bit per step

   // Arithmetic constants
   localparam longint E7_TURN_MUL  = 64'd20015998;   // binary angle units per 1e-7 degree, times 2^24
   localparam longint GAIN_Q30     = 64'd652032874;  // CORDIC gain, Q30
   localparam longint CIRC_MM      = 64'd40075016686;
   localparam int     CIRC_SPLIT   = 18;
   localparam longint CIRC_HI      = CIRC_MM >> CIRC_SPLIT;
   localparam longint CIRC_LO      = CIRC_MM & ((64'd1 << CIRC_SPLIT) - 64'd1);
   localparam int     DEG_PER_TURN = 360;
   localparam longint HALF_TURN    = 64'd1 << 31;
   localparam longint QUARTER_TURN = 64'd1 << 30;

   // Configuration register indexes
   localparam int REG_CALC_ENABLE = 0;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_RESULT
   } state_type;

   // Micro-operations, run in declaration order
   typedef enum logic [4:0] {
      OP_E7_LAT1,
      OP_SC_1,
      OP_E7_LAT2,
      OP_SC_2,
      OP_E7_DLAT,
      OP_SC_H1,
      OP_E7_DLON_H,
      OP_SC_H2,
      OP_E7_DLON,
      OP_SC_D,
      OP_M_SH1SQ,
      OP_M_C1C2,
      OP_M_T1SH2,
      OP_M_ASUM,
      OP_SQ_A,
      OP_SQ_B,
      OP_AT_H,
      OP_M_DHI,
      OP_M_DLO,
      OP_M_XB,
      OP_M_C1S2,
      OP_M_S1C2,
      OP_M_YB,
      OP_AT_B,
      OP_M_DEG
   } op_type;

   localparam op_type OP_FIRST = OP_E7_LAT1;
   localparam op_type OP_LAST  = OP_M_DEG;

   typedef enum logic [1:0] {
      U_MUL,
      U_SINCOS,
      U_ATAN2,
      U_SQRT
   } unit_type;

   // Controller to datapath commands
   typedef struct packed {
      logic   accept;
      logic   start;
      logic   load_out;
      op_type op;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic done;
   } status_type;

   // Which unit carries out an operation
   function automatic unit_type op_unit(input op_type op);
      unit_type u;
      unique case (op)
         OP_SC_1, OP_SC_2, OP_SC_H1, OP_SC_H2, OP_SC_D: u = U_SINCOS;
         OP_AT_H, OP_AT_B:                              u = U_ATAN2;
         OP_SQ_A, OP_SQ_B:                              u = U_SQRT;
         default:                                       u = U_MUL;
      endcase
      return u;
   endfunction

   // atan(2^-i) in binary angle units, 2^32 per turn
   function automatic logic [29:0] atan_turn(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'd536870912;
         5'd1:  v = 30'd316933406;
         5'd2:  v = 30'd167458907;
         5'd3:  v = 30'd85004756;
         5'd4:  v = 30'd42667331;
         5'd5:  v = 30'd21354465;
         5'd6:  v = 30'd10679838;
         5'd7:  v = 30'd5340245;
         5'd8:  v = 30'd2670163;
         5'd9:  v = 30'd1335087;
         5'd10: v = 30'd667544;
         5'd11: v = 30'd333772;
         5'd12: v = 30'd166886;
         5'd13: v = 30'd83443;
         5'd14: v = 30'd41722;
         5'd15: v = 30'd20861;
         5'd16: v = 30'd10430;
         5'd17: v = 30'd5215;
         5'd18: v = 30'd2608;
         5'd19: v = 30'd1304;
         5'd20: v = 30'd652;
         5'd21: v = 30'd326;
         5'd22: v = 30'd163;
         5'd23: v = 30'd81;
         5'd24: v = 30'd41;
         5'd25: v = 30'd20;
         5'd26: v = 30'd10;
         5'd27: v = 30'd5;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

>>> hw/rtl/fdb_cordic.sv
`timescale 1ns / 1ps
// Iterative CORDIC unit: sine/cosine of a binary angle, or atan2 of a vector.
// Depends on fdb_pkg for widths and the arctangent table.
module fdb_cordic import fdb_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
   parameter int FRAC_BITS         = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    rotate,
   input  logic [31:0]             ang,
   input  logic signed [CW-1:0]    vx,
   input  logic signed [CW-1:0]    vy,
   output logic                    done,
   output logic signed [FRAC_BITS+1:0] sin_q,
   output logic signed [FRAC_BITS+1:0] cos_q,
   output logic signed [CW-1:0]    angle
);

   localparam int CNT_W = $clog2(CORDIC_ITERATIONS);
   localparam int QW    = FRAC_BITS + 2;
   localparam int GSH   = 30 - FRAC_BITS;
   localparam longint GAIN_Q = (GAIN_Q30 + ((64'd1 << GSH) >> 1)) >> GSH;
   localparam logic signed [CW-1:0] ONE_C  = CW'(64'd1 << FRAC_BITS);
   localparam logic signed [CW-1:0] GAIN_C = CW'(GAIN_Q);
   localparam logic signed [CW-1:0] HALF_C = CW'(HALF_TURN);
   localparam logic signed [CW-1:0] QUAR_C = CW'(QUARTER_TURN);

   logic signed [CW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [CNT_W-1:0]     i_ff;
   logic                 busy_ff, done_ff, rot_ff, flip_ff, zero_ff;
   logic signed [CW-1:0] sh_x, sh_y, at, a0, cx, cy;
   logic                 pos;

   // One micro-rotation
   always_comb begin
      sh_x = x_ff >>> i_ff;
      sh_y = y_ff >>> i_ff;
      at   = CW'(atan_turn(5'(i_ff)));
      pos  = rot_ff ? !z_ff[CW-1] : y_ff[CW-1];
      if (pos) begin
         x_in = x_ff - sh_y;
         y_in = y_ff + sh_x;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + sh_y;
         y_in = y_ff - sh_x;
         z_in = z_ff + at;
      end
   end

   assign a0 = CW'($signed(ang));

   // Control: run a fixed number of steps, pulse done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            i_ff    <= '0;
         end else if (busy_ff) begin
            if (i_ff == CNT_W'(CORDIC_ITERATIONS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            i_ff <= i_ff + CNT_W'(1);
         end
      end
   end

   // Vector and angle: fold into the right half plane, then iterate
   always_ff @(posedge clock) begin
      if (start) begin
         rot_ff  <= rotate;
         flip_ff <= 1'b0;
         zero_ff <= 1'b0;
         if (rotate) begin
            x_ff <= GAIN_C;
            y_ff <= '0;
            if (a0 > QUAR_C) begin
               z_ff    <= a0 - HALF_C;
               flip_ff <= 1'b1;
            end else if (a0 < -QUAR_C) begin
               z_ff    <= a0 + HALF_C;
               flip_ff <= 1'b1;
            end else begin
               z_ff <= a0;
            end
         end else begin
            zero_ff <= (vx == '0) && (vy == '0);
            if (vx < 0) begin
               x_ff <= -vx;
               y_ff <= -vy;
               z_ff <= (vy >= 0) ? HALF_C : -HALF_C;
            end else begin
               x_ff <= vx;
               y_ff <= vy;
               z_ff <= '0;
            end
         end
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   // Clamp to one and undo the half-turn fold
   always_comb begin
      cx = x_ff;
      cy = y_ff;
      if (cx > ONE_C) cx = ONE_C;
      if (cx < -ONE_C) cx = -ONE_C;
      if (cy > ONE_C) cy = ONE_C;
      if (cy < -ONE_C) cy = -ONE_C;
      sin_q = flip_ff ? -QW'(cy) : QW'(cy);
      cos_q = flip_ff ? -QW'(cx) : QW'(cx);
      angle = zero_ff ? '0 : z_ff;
   end

   assign done = done_ff;

endmodule

>>> hw/rtl/fdb_isqrt.sv
`timescale 1ns / 1ps
// Bit-serial integer square root, rounded to nearest, two radicand bits a step.
// Depends on fdb_pkg for widths.
module fdb_isqrt import fdb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] radicand,
   output logic            done,
   output logic [31:0]     root
);

   localparam int CNT_W = $clog2(SQ_STEPS);

   logic [SQ_W-1:0]  v_ff, res_ff, bit_ff, trial;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;

   assign trial = res_ff + bit_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CNT_W'(SQ_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // Restoring square root step
   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Round up when the remainder exceeds the root
   assign root = res_ff[31:0] + 32'(v_ff > res_ff);
   assign done = done_ff;

endmodule

>>> hw/rtl/fdb_datapath.sv
`timescale 1ns / 1ps
// Datapath: positions, intermediate registers, shared multiplier, CORDIC and
// square root units, held and output results. Depends on fdb_pkg, fdb_cordic, fdb_isqrt.
module fdb_datapath import fdb_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
   parameter int FRAC_BITS         = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic signed [30:0] req_lat_e7,
   input  logic signed [31:0] req_lon_e7,
   input  logic               req_fix_ok,
   output logic signed [31:0] rsp_distance_mm,
   output logic signed [9:0]  rsp_bearing_deg
);

   localparam int QW = FRAC_BITS + 2;
   localparam int RW = FRAC_BITS + 1;
   localparam int AW = 2 * FRAC_BITS + 1;
   localparam logic [AW-1:0] ONE2 = AW'(1) << (2 * FRAC_BITS);
   localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [11:0] DEG_TURN = 12'(DEG_PER_TURN);

   // Positions
   logic signed [30:0] lat_cur_ff, lat_prev_ff;
   logic signed [31:0] lon_cur_ff, lon_prev_ff;
   // Intermediates
   logic [31:0]             ang_ff;
   logic signed [QW-1:0]    s1_ff, c1_ff, s2_ff, c2_ff, sh1_ff, sh2_ff, sd_ff, cd_ff, t1_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic [AW-1:0]           a_ff;
   logic [RW-1:0]           ra_ff, rb_ff;
   logic [31:0]             h_ff;
   logic [49:0]             p_ff;
   logic signed [CW-1:0]    xb_ff, yb_ff, b_ff;
   logic signed [31:0]      dist_ff;
   logic signed [9:0]       brg_ff;
   logic signed [31:0]      out_dist_ff;
   logic signed [9:0]       out_brg_ff;
   // Multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b, mul_a_ff, mul_b_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     mul_go_ff, mul_done_ff;
   // Units
   unit_type                 unit;
   logic                     cor_done, sq_done;
   logic signed [QW-1:0]     cor_sin, cor_cos;
   logic signed [CW-1:0]     cor_angle, cor_vx, cor_vy;
   logic [SQ_W-1:0]          sq_n;
   logic [31:0]              sq_root;
   // Operand and writeback logic
   logic signed [33:0]       e7_val;
   logic [33:0]              e7_mag;
   logic                     e7_neg, e7_half;
   logic [PROD_W-1:0]        e7_r;
   logic [31:0]              e7_ang;
   logic signed [PROD_W-1:0] mq_full, a_sum;
   logic [AW-1:0]            a_clamp;
   logic [PROD_W-1:0]        d_sum, d_t, d_d;
   logic signed [31:0]       d_sat;
   logic signed [CW-1:0]     b_mag;
   logic [PROD_W-1:0]        deg_sum;
   logic signed [11:0]       deg0, deg1, deg2, deg3, deg4;

   assign unit = op_unit(cmd.op);

   // Latch the position on a good fix
   always_ff @(posedge clock) begin
      if (reset) begin
         lat_cur_ff  <= '0;
         lat_prev_ff <= '0;
         lon_cur_ff  <= '0;
         lon_prev_ff <= '0;
      end else if (cmd.accept && req_fix_ok) begin
         lat_prev_ff <= lat_cur_ff;
         lon_prev_ff <= lon_cur_ff;
         lat_cur_ff  <= req_lat_e7;
         lon_cur_ff  <= req_lon_e7;
      end
   end

   // Degree-to-angle operand: magnitude and sign of the selected value
   always_comb begin
      unique case (cmd.op)
         OP_E7_LAT1:   e7_val = 34'(lat_prev_ff);
         OP_E7_LAT2:   e7_val = 34'(lat_cur_ff);
         OP_E7_DLAT:   e7_val = 34'(lat_cur_ff) - 34'(lat_prev_ff);
         OP_E7_DLON_H,
         OP_E7_DLON:   e7_val = 34'(lon_cur_ff) - 34'(lon_prev_ff);
         default:      e7_val = '0;
      endcase
      e7_neg  = e7_val[33];
      e7_mag  = e7_neg ? 34'(-e7_val) : 34'(e7_val);
      e7_half = (cmd.op == OP_E7_DLAT) || (cmd.op == OP_E7_DLON_H);
      b_mag   = b_ff[CW-1] ? -b_ff : b_ff;
   end

   // Multiplier operand select
   always_comb begin
      unique case (cmd.op)
         OP_E7_LAT1, OP_E7_LAT2, OP_E7_DLAT, OP_E7_DLON_H, OP_E7_DLON: begin
            mul_a = MUL_W'(e7_mag);
            mul_b = MUL_W'(E7_TURN_MUL);
         end
         OP_M_SH1SQ: begin mul_a = MUL_W'(sh1_ff); mul_b = MUL_W'(sh1_ff); end
         OP_M_C1C2:  begin mul_a = MUL_W'(c1_ff);  mul_b = MUL_W'(c2_ff);  end
         OP_M_T1SH2,
         OP_M_ASUM:  begin mul_a = MUL_W'(t1_ff);  mul_b = MUL_W'(sh2_ff); end
         OP_M_DHI:   begin mul_a = MUL_W'(h_ff);   mul_b = MUL_W'(CIRC_HI); end
         OP_M_DLO:   begin mul_a = MUL_W'(h_ff);   mul_b = MUL_W'(CIRC_LO); end
         OP_M_XB:    begin mul_a = MUL_W'(c2_ff);  mul_b = MUL_W'(sd_ff);  end
         OP_M_C1S2:  begin mul_a = MUL_W'(c1_ff);  mul_b = MUL_W'(s2_ff);  end
         OP_M_S1C2:  begin mul_a = MUL_W'(s1_ff);  mul_b = MUL_W'(c2_ff);  end
         OP_M_YB:    begin mul_a = MUL_W'(t1_ff);  mul_b = MUL_W'(cd_ff);  end
         OP_M_DEG:   begin mul_a = MUL_W'(b_mag);  mul_b = MUL_W'(DEG_PER_TURN); end
         default:    begin mul_a = '0;             mul_b = '0;             end
      endcase
   end

   // Shared multiplier: register operands, then product
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_go_ff   <= 1'b0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_go_ff   <= cmd.start && (unit == U_MUL);
         mul_done_ff <= mul_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mul_a_ff <= mul_a;
         mul_b_ff <= mul_b;
      end
      prod_ff <= mul_a_ff * mul_b_ff;
   end

   // CORDIC and square root operands
   always_comb begin
      if (cmd.op == OP_AT_H) begin
         cor_vx = CW'(rb_ff);
         cor_vy = CW'(ra_ff);
      end else begin
         cor_vx = yb_ff;
         cor_vy = xb_ff;
      end
      sq_n = (cmd.op == OP_SQ_A) ? SQ_W'(a_ff) : SQ_W'(ONE2 - a_ff);
   end

   fdb_cordic #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
      .FRAC_BITS         (FRAC_BITS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start && ((unit == U_SINCOS) || (unit == U_ATAN2))),
      .rotate (unit == U_SINCOS),
      .ang    (ang_ff),
      .vx     (cor_vx),
      .vy     (cor_vy),
      .done   (cor_done),
      .sin_q  (cor_sin),
      .cos_q  (cor_cos),
      .angle  (cor_angle)
   );

   fdb_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start && (unit == U_SQRT)),
      .radicand (sq_n),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign status.done = mul_done_ff | cor_done | sq_done;

   // Writeback arithmetic
   always_comb begin
      // degree to binary angle, rounded half away from zero
      if (e7_half) begin
         e7_r = (PROD_W'(prod_ff) + (PROD_W'(1) << 24)) >> 25;
      end else begin
         e7_r = (PROD_W'(prod_ff) + (PROD_W'(1) << 23)) >> 24;
      end
      e7_ang = e7_neg ? -e7_r[31:0] : e7_r[31:0];

      // rounded fixed-point product
      mq_full = (prod_ff + HALF_Q) >>> FRAC_BITS;

      // haversine term, clamped to [0, one squared]
      a_sum = acc_ff + prod_ff;
      if (a_sum[PROD_W-1]) begin
         a_clamp = '0;
      end else if (a_sum > PROD_W'(ONE2)) begin
         a_clamp = ONE2;
      end else begin
         a_clamp = AW'(a_sum);
      end

      // distance: angle times circumference, two rounded shifts, saturate
      d_sum = (PROD_W'(p_ff) << CIRC_SPLIT) + PROD_W'(prod_ff) + PROD_W'(32768);
      d_t   = d_sum >> 16;
      d_d   = (d_t + PROD_W'(16384)) >> 15;
      d_sat = (d_d[PROD_W-1:31] != '0) ? 32'sh7FFF_FFFF : 32'(d_d);

      // bearing: angle to whole degrees, wrapped into one turn
      deg_sum = PROD_W'(prod_ff) + (PROD_W'(1) << 31);
      deg0    = {1'b0, deg_sum[42:32]};
      deg1    = b_ff[CW-1] ? -deg0 : deg0;
      deg2    = deg1[11] ? deg1 + DEG_TURN : deg1;
      deg3    = deg2[11] ? deg2 + DEG_TURN : deg2;
      deg4    = (deg3 >= DEG_TURN) ? deg3 - DEG_TURN : deg3;
      if (deg4 >= DEG_TURN) deg4 = deg4 - DEG_TURN;
   end

   // Intermediate writeback when the active unit finishes
   always_ff @(posedge clock) begin
      if (status.done) begin
         unique case (cmd.op)
            OP_E7_LAT1, OP_E7_LAT2, OP_E7_DLAT, OP_E7_DLON_H, OP_E7_DLON:
               ang_ff <= e7_ang;
            OP_SC_1:    begin s1_ff <= cor_sin; c1_ff <= cor_cos; end
            OP_SC_2:    begin s2_ff <= cor_sin; c2_ff <= cor_cos; end
            OP_SC_H1:   sh1_ff <= cor_sin;
            OP_SC_H2:   sh2_ff <= cor_sin;
            OP_SC_D:    begin sd_ff <= cor_sin; cd_ff <= cor_cos; end
            OP_M_SH1SQ: acc_ff <= prod_ff;
            OP_M_C1C2,
            OP_M_T1SH2,
            OP_M_S1C2:  t1_ff <= QW'(mq_full);
            OP_M_ASUM:  a_ff <= a_clamp;
            OP_SQ_A:    ra_ff <= RW'(sq_root);
            OP_SQ_B:    rb_ff <= RW'(sq_root);
            OP_AT_H:    h_ff <= cor_angle[CW-1] ? 32'd0 : 32'(cor_angle);
            OP_M_DHI:   p_ff <= 50'(prod_ff);
            OP_M_XB:    xb_ff <= CW'(mq_full);
            OP_M_C1S2:  yb_ff <= CW'(mq_full);
            OP_M_YB:    yb_ff <= yb_ff - CW'(mq_full);
            OP_AT_B:    b_ff <= cor_angle;
            default:    ;
         endcase
      end
   end

   // Held results
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= -32'sd1;
         brg_ff  <= -10'sd1;
      end else if (status.done) begin
         if (cmd.op == OP_M_DLO) dist_ff <= d_sat;
         if (cmd.op == OP_M_DEG) brg_ff  <= 10'(deg4);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_dist_ff <= dist_ff;
         out_brg_ff  <= brg_ff;
      end
   end

   assign rsp_distance_mm = out_dist_ff;
   assign rsp_bearing_deg = out_brg_ff;

endmodule

>>> hw/rtl/fdb_ctrl.sv
`timescale 1ns / 1ps
// Controller: accepts a transaction, steps the datapath through its operations
// and hands the result to the output register. Depends on fdb_pkg.
module fdb_ctrl import fdb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       calc_enable,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = OP_FIRST;
               state_in = calc_enable ? ST_ISSUE : ST_RESULT;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (status.done) begin
               if (op_ff == OP_LAST) begin
                  state_in = ST_RESULT;
               end else begin
                  op_in    = op_type'(op_ff + 5'd1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.start    = (state_ff == ST_ISSUE);
      cmd.load_out = (state_ff == ST_RESULT) && out_free;
      cmd.op       = op_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/fix_distance_bearing.sv
`timescale 1ns / 1ps
// Fix distance and bearing, top level. Depends on fdb_pkg, fdb_ctrl, fdb_datapath.
//
// Usage:
//   req channel: one position fix per transaction (req_lat_e7, req_lon_e7 in
//   1e-7 degree, req_fix_ok). A good fix moves the current position to the
//   previous one and latches the new one.
//   rsp channel: one result per fix: rsp_distance_mm (great-circle distance,
//   saturated) and rsp_bearing_deg (0..359). With calc_enable clear, the last
//   held results are returned; both are -1 until the first calculation.
//   csr port: register 0 at byte address 0 is calc_enable (bit 0, reset 1).
// Operation:
//   One fix at a time. A calculation runs 25 operations on one shared
//   multiplier, one CORDIC unit (seven uses) and one square-root unit (two
//   uses), then loads the output register. With calc_enable clear a fix
//   skips the operations and goes straight to loading the output register.
// Reset clears positions to (0,0), results to -1 and calc_enable to 1.
// A result waits in the output register while rsp_stall is high; req_stall
// stays high until that result has been loaded.
module fix_distance_bearing import fdb_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
   parameter int FRAC_BITS         = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_lat_e7,
   input  logic signed [31:0] req_lon_e7,
   input  logic               req_fix_ok,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_distance_mm,
   output logic signed [9:0]  rsp_bearing_deg,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic       calc_enable_ff;
   logic       csr_hit;
   cmd_type    cmd;
   status_type status;

   // Register write on the access phase
   assign csr_hit = (32'(csr_paddr[2]) == REG_CALC_ENABLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         calc_enable_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         calc_enable_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = csr_hit ? {31'd0, calc_enable_ff} : 32'd0;
   assign csr_pready = 1'b1;

   fdb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .calc_enable (calc_enable_ff),
      .status      (status),
      .cmd         (cmd)
   );

   fdb_datapath #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
      .FRAC_BITS         (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_lat_e7      (req_lat_e7),
      .req_lon_e7      (req_lon_e7),
      .req_fix_ok      (req_fix_ok),
      .rsp_distance_mm (rsp_distance_mm),
      .rsp_bearing_deg (rsp_bearing_deg)
   );

endmodule

>>> test/fdb_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the fix distance and bearing block: watches the req, rsp and csr ports,
// predicts distance and bearing per fix in fixed point and compares results in order.
// Depends on nothing but the block's port widths.
module fdb_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [30:0] req_lat_e7,
   input  logic signed [31:0] req_lon_e7,
   input  logic               req_fix_ok,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_distance_mm,
   input  logic signed [9:0]  rsp_bearing_deg,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 mismatch_count,
   output int                 results_pending
);

   localparam int     STEPS    = 24;
   localparam int     FRAC     = 30;
   localparam longint ONE      = 64'sd1 <<< FRAC;
   localparam longint GAIN     = 64'sd652032874;
   localparam longint E7_MUL   = 64'sd20015998;
   localparam longint CIRC     = 64'sd40075016686;
   localparam longint HALF     = 64'sd1 <<< 31;
   localparam longint QUARTER  = 64'sd1 <<< 30;
   localparam longint FULL     = 64'sd1 <<< 32;
   localparam logic [2:0] ADDR_CALC_ENABLE = 3'd0;

   localparam longint ARC_STEP [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   typedef struct {
      logic signed [31:0] distance;
      logic signed [9:0]  bearing;
   } leg_type;

   leg_type expected_legs[$];
   longint  fix_lat, fix_lon, last_lat, last_lon, kept_distance, kept_bearing;
   logic    calc_on;

   assign results_pending = expected_legs.size();

   function automatic longint mul_round(input longint a, input longint b);
      return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   // degrees e7 to binary angle, rounded half away from zero
   function automatic longint to_angle(input longint v, input int sh);
      longint m;
      m = v < 0 ? -v : v;
      m = (m * E7_MUL + (64'sd1 <<< (sh - 1))) >>> sh;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint clip_one(input longint v);
      return v > ONE ? ONE : (v < -ONE ? -ONE : v);
   endfunction

   function automatic void rotate_sincos(input longint ang, output longint s,
                                         output longint c);
      longint a, x, y, nx;
      logic   flip;
      a = ang & 64'hFFFF_FFFF;
      x = GAIN; y = 0; flip = 1'b0;
      if (a >= HALF) a -= FULL;
      if (a > QUARTER) begin
         a -= HALF; flip = 1'b1;
      end else if (a < -QUARTER) begin
         a += HALF; flip = 1'b1;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); a -= ARC_STEP[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); a += ARC_STEP[i];
         end
         x = nx;
      end
      x = clip_one(x); y = clip_one(y);
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint vector_angle(input longint im, input longint re);
      longint z, nx;
      z = 0;
      if (re == 0 && im == 0) return 0;
      if (re < 0) begin
         z = im >= 0 ? HALF : -HALF;
         re = -re; im = -im;
      end
      for (int i = 0; i < STEPS; i++) begin
         if (im >= 0) begin
            nx = re + (im >>> i); im = im - (re >>> i); z += ARC_STEP[i];
         end else begin
            nx = re - (im >>> i); im = im + (re >>> i); z -= ARC_STEP[i];
         end
         re = nx;
      end
      return z;
   endfunction

   function automatic longint unsigned root_nearest(input longint unsigned n);
      longint unsigned v, res, probe;
      v = n; res = 0; probe = 64'h4000_0000_0000_0000;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v -= res + probe; res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      if (n - res * res > res) res++;
      return res;
   endfunction

   // great-circle distance and initial bearing from the last fix to the current one
   function automatic void compute_leg();
      longint s1, c1, s2, c2, sh1, sh2, sd, cd, unused, a, h, t, d, xb, yb, b, deg;
      longint unsigned mag;
      rotate_sincos(to_angle(last_lat, 24), s1, c1);
      rotate_sincos(to_angle(fix_lat, 24), s2, c2);
      rotate_sincos(to_angle(fix_lat - last_lat, 25), sh1, unused);
      rotate_sincos(to_angle(fix_lon - last_lon, 25), sh2, unused);
      rotate_sincos(to_angle(fix_lon - last_lon, 24), sd, cd);
      a = sh1 * sh1 + mul_round(mul_round(c1, c2), sh2) * sh2;
      if (a < 0) a = 0;
      if (a > ONE * ONE) a = ONE * ONE;
      h = vector_angle(longint'(root_nearest(a)), longint'(root_nearest(ONE * ONE - a)));
      if (h < 0) h = 0;
      t = (h >>> 16) * CIRC + (((h & 64'hFFFF) * CIRC + 32768) >>> 16);
      d = (t + 16384) >>> 15;
      kept_distance = d > 64'sd2147483647 ? 64'sd2147483647 : d;
      xb = mul_round(c2, sd);
      yb = mul_round(c1, s2) - mul_round(mul_round(s1, c2), cd);
      b = vector_angle(xb, yb);
      mag = b < 0 ? -b : b;
      mag = (mag * 360 + (64'd1 << 31)) >> 32;
      deg = b < 0 ? -longint'(mag) : longint'(mag);
      while (deg < 0) deg += 360;
      while (deg >= 360) deg -= 360;
      kept_bearing = deg;
   endfunction

   always @(posedge clock) begin
      leg_type got, want;
      if (reset) begin
         expected_legs.delete();
         fix_lat = 0; fix_lon = 0; last_lat = 0; last_lon = 0;
         kept_distance = -1; kept_bearing = -1;
         calc_on = 1'b1;
         mismatch_count = 0;
      end else begin
         // compare the returned transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_legs.size() == 0) begin
               $error("unexpected result: distance_mm %0d bearing_deg %0d",
                      rsp_distance_mm, rsp_bearing_deg);
               mismatch_count++;
            end else begin
               want = expected_legs.pop_front();
               if (rsp_distance_mm !== want.distance) begin
                  $error("distance_mm: expected %0d, got %0d", want.distance,
                         rsp_distance_mm);
                  mismatch_count++;
               end
               if (rsp_bearing_deg !== want.bearing) begin
                  $error("bearing_deg: expected %0d, got %0d", want.bearing,
                         rsp_bearing_deg);
                  mismatch_count++;
               end
            end
         end
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ADDR_CALC_ENABLE)
            calc_on = csr_pwdata[0];
         // predict each accepted fix
         if (req_valid && !req_stall) begin
            if (req_fix_ok) begin
               last_lat = fix_lat; last_lon = fix_lon;
               fix_lat = longint'(req_lat_e7); fix_lon = longint'(req_lon_e7);
            end
            if (calc_on) compute_leg();
            got.distance = kept_distance[31:0];
            got.bearing  = kept_bearing[9:0];
            expected_legs.push_back(got);
         end
      end
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for fix_distance_bearing: drives position fixes and register writes,
// stalls the result side, and reports the verdict. Depends on fdb_checker and the RTL.
module tb_top;

   localparam int  LATENCY      = 7 * 24 + 131;
   localparam int  RANDOM_FIXES = 1300;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [2:0] ADDR_CALC_ENABLE = 3'd0;
   localparam logic [2:0] ADDR_UNUSED      = 3'd4;

   logic               clock, reset;
   logic               req_valid, req_stall, req_fix_ok;
   logic signed [30:0] req_lat_e7;
   logic signed [31:0] req_lon_e7;
   logic               rsp_valid, rsp_stall;
   logic signed [31:0] rsp_distance_mm;
   logic signed [9:0]  rsp_bearing_deg;
   logic               csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata, csr_prdata;
   int                 mismatch_count, results_pending;
   int                 burst_left;
   longint             cycle_count;
   int                 stall_mode, stall_left;
   int                 lat_now;
   longint             lon_now;

   fix_distance_bearing u_top (.*);

   fdb_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // result-side stall: switch among no, light and heavy back-pressure
   initial begin
      stall_mode = 0;
      stall_left = 0;
   end
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // send one fix; hold valid across a burst, drop it for a gap at burst end
   task automatic send_fix(input logic signed [30:0] lat, input logic signed [31:0] lon,
                           input logic ok);
      req_valid  <= 1'b1;
      req_lat_e7 <= lat;
      req_lon_e7 <= lon;
      req_fix_ok <= ok;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(0, 12);
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   endtask

   // let every result come back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   // one register write: setup then access
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // mostly plausible fixes near the last one, some global jumps, some raw noise
   task automatic random_fix();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
         lat_now += $signed($urandom_range(0, 200000)) - 100000;
         lon_now += $signed($urandom_range(0, 200000)) - 100000;
         if (lat_now > 900000000) lat_now = 900000000;
         if (lat_now < -900000000) lat_now = -900000000;
         if (lon_now > 1800000000) lon_now = lon_now - 3600000000;
         if (lon_now < -1800000000) lon_now = lon_now + 3600000000;
         send_fix(31'(lat_now), 32'(lon_now), $urandom_range(0, 9) != 0);
      end else if (kind < 85) begin
         lat_now = $signed($urandom_range(0, 1800000000)) - 900000000;
         lon_now = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
         send_fix(31'(lat_now), 32'(lon_now), $urandom_range(0, 9) != 0);
      end else begin
         send_fix(31'($urandom()), 32'($urandom()), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_lat_e7  = '0;
      req_lon_e7  = '0;
      req_fix_ok  = 1'b0;
      rsp_stall   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      burst_left  = 0;
      lat_now     = 0;
      lon_now     = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: disabled first, so the never-computed values come back
      write_reg(ADDR_CALC_ENABLE, 32'h0);
      send_fix(31'(123456789), 32'(-98765432), 1'b1);
      send_fix(31'(0), 32'(0), 1'b0);
      drain();
      write_reg(ADDR_CALC_ENABLE, 32'hFFFF_FFFF);
      // identical points from reset, then field extremes and a bad fix
      send_fix(31'(0), 32'(0), 1'b1);
      send_fix(31'(0), 32'(0), 1'b1);
      send_fix(31'(900000000), 32'(1800000000), 1'b1);
      send_fix(31'(-900000000), 32'(-1800000000), 1'b1);
      send_fix(31'(-900000000), 32'(-1800000000), 1'b1);
      send_fix(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
      send_fix(31'sh4000_0000, 32'sh8000_0000, 1'b1);
      send_fix(31'sh4000_0000, 32'sh8000_0000, 1'b0);
      send_fix(31'(0), 32'(1800000000), 1'b1);
      send_fix(31'(0), 32'(-1800000000), 1'b1);
      send_fix(31'(450000000), 32'(100000000), 1'b1);
      send_fix(31'(-450000000), 32'(-1700000000), 1'b1);
      send_fix(31'(-450000001), 32'(-1700000000), 1'b1);
      send_fix(31'(-450000001), 32'(-1699999999), 1'b1);
      send_fix(31'(899999999), 32'(0), 1'b1);
      send_fix(31'(900000000), 32'(900000000), 1'b1);
      send_fix(31'(-1), 32'(-1), 1'b1);
      drain();
      write_reg(ADDR_UNUSED, 32'h0);

      // random phases, toggling the enable between them
      for (int phase = 0; phase < 8; phase++) begin
         for (int n = 0; n < RANDOM_FIXES / 8; n++) random_fix();
         drain();
         write_reg(ADDR_CALC_ENABLE,
                   {31'($urandom_range(0, 32'h7FFF_FFFF)), phase[0]});
         if ($urandom_range(0, 3) == 0) write_reg(ADDR_UNUSED, $urandom());
      end
      write_reg(ADDR_CALC_ENABLE, 32'h1);
      for (int n = 0; n < 20; n++) random_fix();
      drain();

      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
